### hdl/bts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg
// Types, character codes and the byte class table of the token scanner.
// ----------------------------------------------------------------------------
package bts_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_IDENT   = 4'd1,
    MODE_ZERO    = 4'd2,
    MODE_DEC     = 4'd3,
    MODE_HEX     = 4'd4,
    MODE_COMP    = 4'd5,
    MODE_ARITH   = 4'd6,
    MODE_PLUS    = 4'd7,
    MODE_MINUS   = 4'd8,
    MODE_SLASH   = 4'd9,
    MODE_COMMENT = 4'd10,
    MODE_STRING  = 4'd11
  } scan_mode_t;

  localparam logic [5:0] CLS_ALPHA  = 6'h01;
  localparam logic [5:0] CLS_DIGIT  = 6'h02;
  localparam logic [5:0] CLS_ALNUM  = 6'h03;
  localparam logic [5:0] CLS_WSPACE = 6'h04;
  localparam logic [5:0] CLS_COMP   = 6'h08;
  localparam logic [5:0] CLS_ARITH  = 6'h10;
  localparam logic [5:0] CLS_HEX    = 6'h20;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_X_UP   = 8'h58;
  localparam logic [7:0] CH_X_LO   = 8'h78;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       line_end;
    logic       open_string;
  } result_t;

  // results of one input byte, r0 first; r1 used only when two is set
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } bundle_t;

  function automatic result_t mk_res(input logic [7:0] ch, input logic last,
                                     input logic le, input logic os);
    result_t r;
    r.ch          = ch;
    r.last        = last;
    r.line_end    = le;
    r.open_string = os;
    return r;
  endfunction

  function automatic logic [5:0] char_class(input logic [6:0] idx);
    logic [5:0] c;
    case (idx) inside
      7'h08, 7'h09, 7'h0D, 7'h1A, 7'h1D, 7'h20:           c = CLS_WSPACE;
      7'h21, [7'h3C:7'h3E]:                               c = CLS_COMP;
      7'h25, 7'h26, 7'h2A, 7'h2B, 7'h2D, 7'h2F, 7'h5E, 7'h7C: c = CLS_ARITH;
      [7'h30:7'h39]:                                      c = CLS_DIGIT | CLS_HEX;
      [7'h41:7'h46], [7'h61:7'h66]:                       c = CLS_ALPHA | CLS_HEX;
      [7'h47:7'h5A], 7'h5F, [7'h67:7'h7A]:                c = CLS_ALPHA;
      default:                                            c = 6'h00;
    endcase
    return c;
  endfunction

endpackage

### hdl/basic_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// basic_token_scanner
// Streaming tokeniser: source bytes in, token characters and line ends out.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle; its class and the scan mode are worked
// out in the cycle it arrives, and the zero, one or two result transactions it
// causes go into a bundle queue (QUEUE_DEPTH entries). Results leave one per
// cycle while out_stall is low, through the queue, a current-bundle register
// and a registered output, so the output port sets the sustained rate: a byte
// that yields two results takes two output transactions. The input stalls only
// while the queue is full.
module basic_token_scanner #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_token_last,
  output logic       out_line_end,
  output logic       out_open_string
);

  logic             accept;
  logic             push, pop, q_not_empty, q_full;
  bts_pkg::bundle_t push_data, pop_data;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  bts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_byte),
    .push      (push),
    .push_data (push_data)
  );

  bts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  bts_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_data          (pop_data),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_token_last  (out_token_last),
    .out_line_end    (out_line_end),
    .out_open_string (out_open_string)
  );

endmodule

### hdl/bts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_front
// Classifies each accepted byte against the scan mode and the held character
// and produces the bundle of results that the byte causes.
// ----------------------------------------------------------------------------
module bts_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  output logic             push,
  output bts_pkg::bundle_t push_data
);

  bts_pkg::scan_mode_t mode_r, mode_nxt;
  logic [7:0]          held_r, held_nxt;
  logic                hvld_r, hvld_nxt;

  logic [5:0]          cls;
  logic [1:0]          n;
  bts_pkg::result_t    r0, r1, s;
  logic                s_v;
  logic                go, brk, start_en;
  bts_pkg::scan_mode_t go_mode;

  assign cls = bts_pkg::char_class(in_byte[6:0]);

  always_comb begin
    n        = 2'd0;
    r0       = '0;
    r1       = '0;
    s        = '0;
    s_v      = 1'b0;
    go       = 1'b0;
    brk      = 1'b0;
    start_en = 1'b0;
    go_mode  = bts_pkg::MODE_IDLE;
    mode_nxt = mode_r;
    held_nxt = held_r;
    hvld_nxt = hvld_r;

    case (mode_r)
      bts_pkg::MODE_IDENT: begin
        if ((cls & bts_pkg::CLS_ALNUM) != 6'h00) begin
          go = 1'b1; go_mode = bts_pkg::MODE_IDENT;
        end else if (in_byte == bts_pkg::CH_DOLLAR) begin
          r0 = bts_pkg::mk_res(held_r, 1'b0, 1'b0, 1'b0);
          r1 = bts_pkg::mk_res(in_byte, 1'b1, 1'b0, 1'b0);
          n = 2'd2;
          mode_nxt = bts_pkg::MODE_IDLE; held_nxt = 8'h00; hvld_nxt = 1'b0;
        end else begin
          brk = 1'b1;
        end
      end
      bts_pkg::MODE_ZERO: begin
        if (in_byte == bts_pkg::CH_X_LO || in_byte == bts_pkg::CH_X_UP) begin
          go = 1'b1; go_mode = bts_pkg::MODE_HEX;
        end else if ((cls & bts_pkg::CLS_DIGIT) != 6'h00) begin
          go = 1'b1; go_mode = bts_pkg::MODE_DEC;
        end else begin
          brk = 1'b1;
        end
      end
      bts_pkg::MODE_DEC: begin
        if ((cls & bts_pkg::CLS_DIGIT) != 6'h00) begin
          go = 1'b1; go_mode = bts_pkg::MODE_DEC;
        end else begin
          brk = 1'b1;
        end
      end
      bts_pkg::MODE_HEX: begin
        if ((cls & bts_pkg::CLS_HEX) != 6'h00) begin
          go = 1'b1; go_mode = bts_pkg::MODE_HEX;
        end else begin
          brk = 1'b1;
        end
      end
      bts_pkg::MODE_COMP: begin
        if ((cls & bts_pkg::CLS_COMP) != 6'h00) begin
          go = 1'b1; go_mode = bts_pkg::MODE_COMP;
        end else begin
          brk = 1'b1;
        end
      end
      bts_pkg::MODE_ARITH: begin
        if ((cls & bts_pkg::CLS_ARITH) != 6'h00) begin
          go = 1'b1; go_mode = bts_pkg::MODE_ARITH;
        end else begin
          brk = 1'b1;
        end
      end
      bts_pkg::MODE_PLUS, bts_pkg::MODE_MINUS: begin
        if (in_byte == held_r) begin
          r0 = bts_pkg::mk_res(held_r, 1'b0, 1'b0, 1'b0);
          r1 = bts_pkg::mk_res(in_byte, 1'b1, 1'b0, 1'b0);
          n = 2'd2;
          mode_nxt = bts_pkg::MODE_IDLE; held_nxt = 8'h00; hvld_nxt = 1'b0;
        end else if ((cls & bts_pkg::CLS_ARITH) != 6'h00) begin
          go = 1'b1; go_mode = bts_pkg::MODE_ARITH;
        end else begin
          brk = 1'b1;
        end
      end
      bts_pkg::MODE_SLASH: begin
        if (in_byte == bts_pkg::CH_SLASH) begin
          mode_nxt = bts_pkg::MODE_COMMENT; held_nxt = 8'h00; hvld_nxt = 1'b0;
        end else if ((cls & bts_pkg::CLS_ARITH) != 6'h00) begin
          go = 1'b1; go_mode = bts_pkg::MODE_ARITH;
        end else begin
          brk = 1'b1;
        end
      end
      bts_pkg::MODE_COMMENT: begin
        if (in_byte == bts_pkg::CH_LF || in_byte == bts_pkg::CH_CR ||
            in_byte == bts_pkg::CH_NUL) begin
          r0 = bts_pkg::mk_res(8'h00, 1'b0, 1'b1, 1'b0);
          n = 2'd1;
          mode_nxt = bts_pkg::MODE_IDLE; held_nxt = 8'h00; hvld_nxt = 1'b0;
        end
      end
      bts_pkg::MODE_STRING: begin
        if (in_byte == bts_pkg::CH_QUOTE) begin
          r0 = bts_pkg::mk_res(in_byte, 1'b1, 1'b0, 1'b0);
          n = 2'd1;
          mode_nxt = bts_pkg::MODE_IDLE; held_nxt = 8'h00; hvld_nxt = 1'b0;
        end else if (in_byte == bts_pkg::CH_NUL) begin
          // text ended inside the string: close it and flag both results
          r0 = bts_pkg::mk_res(bts_pkg::CH_QUOTE, 1'b1, 1'b0, 1'b1);
          r1 = bts_pkg::mk_res(8'h00, 1'b0, 1'b1, 1'b1);
          n = 2'd2;
          mode_nxt = bts_pkg::MODE_IDLE; held_nxt = 8'h00; hvld_nxt = 1'b0;
        end else begin
          r0 = bts_pkg::mk_res(in_byte, 1'b0, 1'b0, 1'b0);
          n = 2'd1;
        end
      end
      default: begin
        start_en = 1'b1;
      end
    endcase

    if (go) begin
      r0 = bts_pkg::mk_res(held_r, 1'b0, 1'b0, 1'b0);
      n = 2'd1;
      held_nxt = in_byte;
      hvld_nxt = 1'b1;
      mode_nxt = go_mode;
    end

    if (brk) begin
      start_en = 1'b1;
      if (hvld_r) begin
        r0 = bts_pkg::mk_res(held_r, 1'b1, 1'b0, 1'b0);
        n = 2'd1;
      end
    end

    if (start_en) begin
      mode_nxt = bts_pkg::MODE_IDLE;
      held_nxt = 8'h00;
      hvld_nxt = 1'b0;
      if (in_byte == bts_pkg::CH_NUL || in_byte == bts_pkg::CH_LF) begin
        s = bts_pkg::mk_res(8'h00, 1'b0, 1'b1, 1'b0); s_v = 1'b1;
      end else if ((cls & bts_pkg::CLS_WSPACE) != 6'h00) begin
        s_v = 1'b0;
      end else if (in_byte == bts_pkg::CH_APOS) begin
        mode_nxt = bts_pkg::MODE_COMMENT;
      end else if (in_byte == bts_pkg::CH_SLASH) begin
        mode_nxt = bts_pkg::MODE_SLASH; held_nxt = in_byte; hvld_nxt = 1'b1;
      end else if (in_byte == bts_pkg::CH_SEMI) begin
        s = bts_pkg::mk_res(in_byte, 1'b1, 1'b0, 1'b0); s_v = 1'b1;
      end else if ((cls & bts_pkg::CLS_ALPHA) != 6'h00) begin
        mode_nxt = bts_pkg::MODE_IDENT; held_nxt = in_byte; hvld_nxt = 1'b1;
      end else if ((cls & bts_pkg::CLS_DIGIT) != 6'h00) begin
        mode_nxt = (in_byte == bts_pkg::CH_ZERO) ? bts_pkg::MODE_ZERO
                                                 : bts_pkg::MODE_DEC;
        held_nxt = in_byte; hvld_nxt = 1'b1;
      end else if ((cls & bts_pkg::CLS_COMP) != 6'h00) begin
        mode_nxt = bts_pkg::MODE_COMP; held_nxt = in_byte; hvld_nxt = 1'b1;
      end else if (in_byte == bts_pkg::CH_PLUS) begin
        mode_nxt = bts_pkg::MODE_PLUS; held_nxt = in_byte; hvld_nxt = 1'b1;
      end else if (in_byte == bts_pkg::CH_MINUS) begin
        mode_nxt = bts_pkg::MODE_MINUS; held_nxt = in_byte; hvld_nxt = 1'b1;
      end else if ((cls & bts_pkg::CLS_ARITH) != 6'h00) begin
        mode_nxt = bts_pkg::MODE_ARITH; held_nxt = in_byte; hvld_nxt = 1'b1;
      end else if (in_byte == bts_pkg::CH_QUOTE) begin
        s = bts_pkg::mk_res(in_byte, 1'b0, 1'b0, 1'b0); s_v = 1'b1;
        mode_nxt = bts_pkg::MODE_STRING;
      end else begin
        s = bts_pkg::mk_res(in_byte, 1'b1, 1'b0, 1'b0); s_v = 1'b1;
      end
      if (s_v) begin
        if (n == 2'd0) begin
          r0 = s; n = 2'd1;
        end else begin
          r1 = s; n = 2'd2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bts_pkg::MODE_IDLE;
      held_r <= 8'h00;
      hvld_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      hvld_r <= hvld_nxt;
    end
  end

  assign push         = accept && (n != 2'd0);
  assign push_data.two = (n == 2'd2);
  assign push_data.r0  = r0;
  assign push_data.r1  = r1;

endmodule

### hdl/bts_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_queue
// Small first-in first-out queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module bts_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bts_pkg::bundle_t push_data,
  input  logic             pop,
  output bts_pkg::bundle_t pop_data,
  output logic             not_empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bts_pkg::bundle_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  function automatic logic [PTR_W-1:0] inc_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= inc_ptr(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= inc_ptr(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign pop_data  = mem[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CNT_W'(DEPTH));

endmodule

### hdl/bts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_back
// Takes bundles from the queue and sends their results one per transaction
// through a registered output stage.
// ----------------------------------------------------------------------------
module bts_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  bts_pkg::bundle_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_char,
  output logic             out_token_last,
  output logic             out_line_end,
  output logic             out_open_string
);

  bts_pkg::bundle_t cur_r;
  logic             cur_vld_r;
  logic             idx_r;
  logic             out_valid_r;
  bts_pkg::result_t out_r;

  logic adv, done;

  assign adv   = cur_vld_r && (!out_valid_r || !out_stall);
  assign done  = adv && (idx_r || !cur_r.two);
  assign q_pop = q_not_empty && (!cur_vld_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r   <= 1'b0;
      idx_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_vld_r <= 1'b1;
        idx_r     <= 1'b0;
      end else if (done) begin
        cur_vld_r <= 1'b0;
        idx_r     <= 1'b0;
      end else if (adv) begin
        idx_r <= 1'b1;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (adv) begin
      out_r <= idx_r ? cur_r.r1 : cur_r.r0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_r.ch;
  assign out_token_last  = out_r.last;
  assign out_line_end    = out_r.line_end;
  assign out_open_string = out_r.open_string;

endmodule

### hdl/bts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_checker
// Port-level checks of the token scanner, bound to the top level.
// ----------------------------------------------------------------------------
module bts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       out_token_last,
  input logic       out_line_end,
  input logic       out_open_string
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char) &&
    $stable(out_token_last) && $stable(out_line_end) && $stable(out_open_string))
    else $error("stalled output transaction changed");

  a_line_end_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_end |-> out_char == 8'h00 && !out_token_last)
    else $error("line end carries a character");

  a_open_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_open_string && !out_line_end |->
    out_char == 8'h22 && out_token_last)
    else $error("open string result is not a closing quote");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind basic_token_scanner bts_checker u_bts_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_char        (out_char),
  .out_token_last  (out_token_last),
  .out_line_end    (out_line_end),
  .out_open_string (out_open_string)
);
